>>> src/rme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles: shared package
// Widths, constants, the CORDIC arctangent table and the half-turn
// pre-rotation used ahead of every vectoring CORDIC.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int ELEM_W          = 16;
    localparam int ELEM_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int ANGLE_W         = 15;
    localparam int CORDIC_STAGES   = 16;
    localparam int GUARD           = 16;

    localparam int IN_DATA_W  = 7 * ELEM_W;
    localparam int OUT_DATA_W = ((3 * ANGLE_W + 7) / 8) * 8;

    // Elements and their products, scaled by the guard shift, fit here with
    // room for the CORDIC gain.
    localparam int PROD_W = 2 * ELEM_W;
    localparam int CW     = PROD_W + GUARD + 2;
    // Binary angle accumulator, 2^32 units per turn plus headroom.
    localparam int ZW     = 34;

    // Magnitude correction: 1/K in Q0.30.
    localparam int KR_W       = 34;
    localparam int INV_GAIN_W = 30;
    localparam int MUL_W      = KR_W + INV_GAIN_W;
    localparam logic [INV_GAIN_W-1:0] INV_GAIN = INV_GAIN_W'(652032874);

    // Degree scaling: 360 * 2^ANGLE_FRAC_BITS per turn.
    localparam int DEG_SCALE_W = 9 + ANGLE_FRAC_BITS;
    localparam logic [DEG_SCALE_W-1:0] DEG_SCALE = DEG_SCALE_W'(360) << ANGLE_FRAC_BITS;
    localparam int DEG_P_W = ZW + DEG_SCALE_W + 1;

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(1) << 31;
    localparam logic signed [ELEM_W-1:0] ELEM_ONE = ELEM_W'(1) << ELEM_FRAC_BITS;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cvec_t;

    // A vector in the left half plane is turned by a half turn so that the
    // CORDIC only has to cover the right half plane.
    function automatic cvec_t prerotate(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        cvec_t v;
        v.x = x;
        v.y = y;
        v.z = '0;
        if (x < 0)
        begin
            v.x = -x;
            v.y = -y;
            v.z = (y >= 0) ? HALF_TURN : -HALF_TURN;
        end
        return v;
    endfunction

endpackage

>>> src/rotation_matrix_to_euler_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles (Z-Y-X)
// Converts a Q1.14 rotation matrix into yaw, pitch and roll in degrees.
// ----------------------------------------------------------------------------
// Pipeline: 2 * CORDIC_STAGES + 6 register stages.
// Throughput: one item per cycle; the whole pipeline advances together and
//             holds while a finished result waits downstream.
// Reset: rst_n clears every valid bit at once; no data is cleared.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles
    import rme_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20 (16 bits each), lowest first
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // yaw_deg, pitch_deg, roll_deg (15 bits each), lowest first, zero padded
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [MUL_W-1:0] RND_Q30 = MUL_W'(1) << 29;
    localparam int PITCH_LIMIT = 91 << ANGLE_FRAC_BITS;

    // Sideband carried alongside the first CORDIC pass.
    typedef struct packed {
        logic signed [ELEM_W-1:0] m20;
        logic                     roll_zero;
        logic                     yaw_zero;
    } side_a_t;

    // Sideband carried alongside the pitch CORDIC pass.
    typedef struct packed {
        logic signed [ZW-1:0] roll_ang;
        logic signed [ZW-1:0] yaw_ang;
        logic                 pitch_zero;
    } side_b_t;

    // The whole pipeline moves when the output slot is free or being taken.
    logic en;
    logic vo_reg;

    assign en            = !vo_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------------------------------------------------------------
    // Stage 1: pick cos/sin stand-ins and form the four yaw products.
    // With m00 and m10 both zero the roll is taken as zero (cos = 1).
    // ---------------------------------------------------------------------
    logic signed [ELEM_W-1:0] in_m00, in_m01, in_m02, in_m10, in_m11, in_m12, in_m20;
    logic signed [ELEM_W-1:0] cs_c, cs_s;
    logic                     cs_zero;

    assign in_m00 = $signed(s_axis_tdata[0*ELEM_W +: ELEM_W]);
    assign in_m01 = $signed(s_axis_tdata[1*ELEM_W +: ELEM_W]);
    assign in_m02 = $signed(s_axis_tdata[2*ELEM_W +: ELEM_W]);
    assign in_m10 = $signed(s_axis_tdata[3*ELEM_W +: ELEM_W]);
    assign in_m11 = $signed(s_axis_tdata[4*ELEM_W +: ELEM_W]);
    assign in_m12 = $signed(s_axis_tdata[5*ELEM_W +: ELEM_W]);
    assign in_m20 = $signed(s_axis_tdata[6*ELEM_W +: ELEM_W]);

    assign cs_zero = (in_m00 == '0) && (in_m10 == '0);
    assign cs_c    = cs_zero ? ELEM_ONE : in_m00;
    assign cs_s    = cs_zero ? '0 : in_m10;

    logic                     v1_reg;
    logic signed [PROD_W-1:0] p_sm02_reg, p_cm12_reg, p_cm11_reg, p_sm01_reg;
    logic signed [ELEM_W-1:0] m00_s1_reg, m10_s1_reg, m20_s1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_sm02_reg <= cs_s * in_m02;
            p_cm12_reg <= cs_c * in_m12;
            p_cm11_reg <= cs_c * in_m11;
            p_sm01_reg <= cs_s * in_m01;
            m00_s1_reg <= in_m00;
            m10_s1_reg <= in_m10;
            m20_s1_reg <= in_m20;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: yaw operands, guard scaling and half-turn pre-rotation.
    // ---------------------------------------------------------------------
    logic signed [CW-1:0] yaw_y, yaw_x, roll_x, roll_y;
    logic                 v2_reg;
    cvec_t                roll_vec_reg, yaw_vec_reg;
    side_a_t              side_a_in_reg;

    assign yaw_y  = (CW'(p_sm02_reg) - CW'(p_cm12_reg)) <<< GUARD;
    assign yaw_x  = (CW'(p_cm11_reg) - CW'(p_sm01_reg)) <<< GUARD;
    assign roll_x = CW'(m00_s1_reg) <<< GUARD;
    assign roll_y = CW'(m10_s1_reg) <<< GUARD;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_vec_reg            <= prerotate(roll_x, roll_y);
            yaw_vec_reg             <= prerotate(yaw_x, yaw_y);
            side_a_in_reg.m20       <= m20_s1_reg;
            side_a_in_reg.roll_zero <= (roll_x == '0) && (roll_y == '0);
            side_a_in_reg.yaw_zero  <= (yaw_x == '0) && (yaw_y == '0);
        end
    end

    // ---------------------------------------------------------------------
    // First CORDIC pass: roll and yaw side by side.
    // ---------------------------------------------------------------------
    logic  va_valid;
    cvec_t roll_out, yaw_out;

    rme_cordic u_cordic_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_vec    (roll_vec_reg),
        .out_valid (va_valid),
        .out_vec   (roll_out)
    );

    rme_cordic u_cordic_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_vec    (yaw_vec_reg),
        .out_valid (),
        .out_vec   (yaw_out)
    );

    side_a_t side_a_reg [CORDIC_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_a_reg[0] <= side_a_in_reg;
            for (int i = 1; i < CORDIC_STAGES; i++)
            begin
                side_a_reg[i] <= side_a_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: the roll magnitude times 1/K gives the pitch x operand.
    // Stage 4: round it and pre-rotate the pitch vector.
    // ---------------------------------------------------------------------
    side_a_t              side_a_out;
    logic [KR_W-1:0]      kr;
    logic                 v3_reg, v4_reg;
    logic [MUL_W-1:0]     mag_prod_reg;
    logic signed [ZW-1:0] roll_ang_s3_reg, yaw_ang_s3_reg;
    logic signed [ELEM_W-1:0] m20_s3_reg;
    logic [MUL_W-1:0]     r_full;
    logic signed [CW-1:0] pitch_x, pitch_y;
    cvec_t                pitch_vec_reg;
    side_b_t              side_b_in_reg;

    assign side_a_out = side_a_reg[CORDIC_STAGES-1];
    assign kr         = roll_out.x[KR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_prod_reg    <= MUL_W'(kr) * MUL_W'(INV_GAIN);
            roll_ang_s3_reg <= side_a_out.roll_zero ? '0 : roll_out.z;
            yaw_ang_s3_reg  <= side_a_out.yaw_zero ? '0 : yaw_out.z;
            m20_s3_reg      <= side_a_out.m20;
        end
    end

    assign r_full  = (mag_prod_reg + RND_Q30) >> 30;
    assign pitch_x = $signed(r_full[CW-1:0]);
    assign pitch_y = -(CW'(m20_s3_reg) <<< GUARD);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_vec_reg            <= prerotate(pitch_x, pitch_y);
            side_b_in_reg.roll_ang   <= roll_ang_s3_reg;
            side_b_in_reg.yaw_ang    <= yaw_ang_s3_reg;
            side_b_in_reg.pitch_zero <= (pitch_x == '0) && (pitch_y == '0);
        end
    end

    // ---------------------------------------------------------------------
    // Second CORDIC pass: pitch, with roll and yaw angles riding along.
    // ---------------------------------------------------------------------
    logic    vb_valid;
    cvec_t   pitch_out;
    side_b_t side_b_reg [CORDIC_STAGES];
    side_b_t side_b_out;

    rme_cordic u_cordic_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_vec    (pitch_vec_reg),
        .out_valid (vb_valid),
        .out_vec   (pitch_out)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_b_reg[0] <= side_b_in_reg;
            for (int i = 1; i < CORDIC_STAGES; i++)
            begin
                side_b_reg[i] <= side_b_reg[i-1];
            end
        end
    end

    assign side_b_out = side_b_reg[CORDIC_STAGES-1];

    // ---------------------------------------------------------------------
    // Last two stages: conversion to degrees; the second is the output.
    // ---------------------------------------------------------------------
    logic signed [ZW-1:0]      pitch_ang;
    logic signed [ANGLE_W-1:0] yaw_deg, pitch_deg, roll_deg;
    logic                      vd1_reg;

    assign pitch_ang = side_b_out.pitch_zero ? '0 : pitch_out.z;

    rme_deg u_deg_yaw (
        .clk (clk),
        .en  (en),
        .ang (side_b_out.yaw_ang),
        .deg (yaw_deg)
    );

    rme_deg u_deg_pitch (
        .clk (clk),
        .en  (en),
        .ang (pitch_ang),
        .deg (pitch_deg)
    );

    rme_deg u_deg_roll (
        .clk (clk),
        .en  (en),
        .ang (side_b_out.roll_ang),
        .deg (roll_deg)
    );

    // Valid bits for the stages that live in this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            vd1_reg <= 1'b0;
            vo_reg  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= s_axis_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= va_valid;
            v4_reg  <= v3_reg;
            vd1_reg <= vb_valid;
            vo_reg  <= vd1_reg;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 3*ANGLE_W){1'b0}}, roll_deg, pitch_deg, yaw_deg};

`ifndef SYNTHESIS
    // A waiting result must freeze the whole pipeline, input included.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while a result is stalled");

    // A zero roll vector must still be zero after the CORDIC, which checks
    // that the sideband stays aligned with the roll pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        va_valid && side_a_out.roll_zero |-> roll_out.x == '0 && roll_out.y == '0)
        else $error("roll sideband out of step with the CORDIC");

    // The pitch x operand is a magnitude, so pitch stays within a quarter turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $signed(pitch_deg) <= PITCH_LIMIT && $signed(pitch_deg) >= -PITCH_LIMIT)
        else $error("pitch outside a quarter turn");

    // An item leaving the second CORDIC reaches the output through vd1_reg and vo_reg while the pipeline moves.
    assert property (@(posedge clk) disable iff (!rst_n)
        en && vb_valid ##1 en |=> m_axis_tvalid)
        else $error("pitch result lost before the output");
`endif

endmodule

>>> src/rme_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vectoring CORDIC pipeline
// One registered micro-rotation per stage; the vector is driven onto the
// x axis while z collects the angle in binary units.
// ----------------------------------------------------------------------------
module rme_cordic
    import rme_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  cvec_t in_vec,
    output logic  out_valid,
    output cvec_t out_vec
);

    cvec_t                    vec_reg [CORDIC_STAGES];
    cvec_t                    stage_in [CORDIC_STAGES];
    logic [CORDIC_STAGES-1:0] vld_reg;
    logic [CORDIC_STAGES-1:0] stage_vld;

    assign stage_in[0]  = in_vec;
    assign stage_vld[0] = in_valid;

    genvar k;
    generate
        for (k = 0; k < CORDIC_STAGES; k++)
        begin : g_stage
            cvec_t                vec_next;
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            logic signed [ZW-1:0] ang;

            if (k > 0)
            begin : g_link
                assign stage_in[k]  = vec_reg[k-1];
                assign stage_vld[k] = vld_reg[k-1];
            end

            always_comb
            begin
                xs       = stage_in[k].x >>> k;
                ys       = stage_in[k].y >>> k;
                ang      = $signed({{(ZW-32){1'b0}}, ATAN_TAB[k]});
                vec_next = stage_in[k];
                if (stage_in[k].y >= 0)
                begin
                    vec_next.x = stage_in[k].x + ys;
                    vec_next.y = stage_in[k].y - xs;
                    vec_next.z = stage_in[k].z + ang;
                end
                else
                begin
                    vec_next.x = stage_in[k].x - ys;
                    vec_next.y = stage_in[k].y + xs;
                    vec_next.z = stage_in[k].z - ang;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    vec_reg[k] <= vec_next;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= stage_vld[k];
                end
            end
        end
    endgenerate

    assign out_vec   = vec_reg[CORDIC_STAGES-1];
    assign out_valid = vld_reg[CORDIC_STAGES-1];

endmodule

>>> src/rme_deg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary angle to degrees
// Two stages: scale by 360 * 2^ANGLE_FRAC_BITS, then round half away from
// zero on the 2^32 turn and keep the low output bits.
// ----------------------------------------------------------------------------
module rme_deg
    import rme_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [ZW-1:0]      ang,
    output logic signed [ANGLE_W-1:0] deg
);

    localparam logic [DEG_P_W-1:0] DEG_RND = DEG_P_W'(1) << 31;

    logic signed [DEG_P_W-1:0] prod_reg;
    logic signed [DEG_P_W-1:0] prod_next;
    logic [DEG_P_W-1:0]        mag;
    logic [DEG_P_W-1:0]        rnd;
    logic [DEG_P_W-1:0]        res;
    logic signed [ANGLE_W-1:0] deg_reg;
    logic signed [ANGLE_W-1:0] deg_next;

    always_comb
    begin
        prod_next = DEG_P_W'(ang) * $signed({1'b0, DEG_SCALE});
        mag       = prod_reg[DEG_P_W-1] ? DEG_P_W'(-prod_reg) : DEG_P_W'(prod_reg);
        rnd       = (mag + DEG_RND) >> 32;
        res       = prod_reg[DEG_P_W-1] ? -rnd : rnd;
        deg_next  = $signed(res[ANGLE_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            deg_reg  <= deg_next;
        end
    end

    assign deg = deg_reg;

endmodule
